@@ rtl/tbk_pkg.sv @@
// Shared constants, types and the pair ordering functions for the top/bottom tracker.
`timescale 1ns / 1ps
package tbk_pkg;
  localparam int KEEP = 10;
  localparam int NLISTS = 6;
  localparam int NSTATS = 3;
  localparam int FILL_W = $clog2(KEEP + 1);
  localparam int LIST_W = $clog2(NLISTS);

  localparam logic DIR_TOP = 1'b0;
  localparam logic DIR_BOT = 1'b1;

  typedef struct packed {
    logic signed [63:0] value;
    logic [63:0] name;
  } pair_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } lane_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_INSERT = 3'b010,
    ST_DRAIN  = 3'b100
  } state_t;

  function automatic logic pair_less(input pair_t a, input pair_t b);
    logic r;
    if (a.value != b.value) begin
      r = (a.value < b.value);
    end else begin
      r = (a.name < b.name);
    end
    return r;
  endfunction

  function automatic logic pair_worse(input logic dir, input pair_t a, input pair_t b);
    logic r;
    if (dir == DIR_TOP) begin
      r = pair_less(a, b);
    end else begin
      r = pair_less(b, a);
    end
    return r;
  endfunction
endpackage

@@ rtl/tbk_lane.sv @@
// One sorted list lane: KEEP slots ordered worst first, insertion and pop by shifting.
`timescale 1ns / 1ps
module tbk_lane
  import tbk_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              dir,
  input  lane_cmd_t         cmd,
  input  pair_t             pin,
  output pair_t             head,
  output logic [FILL_W-1:0] fill
);
  pair_t slot [KEEP];
  pair_t slot_next [KEEP];
  logic [KEEP-1:0] w;
  logic full;

  assign full = (fill == FILL_W'(KEEP));
  assign head = slot[0];

  genvar i;
  generate
    for (i = 0; i < KEEP; i++) begin : g_slot
      pair_t full_next;
      pair_t open_next;
      pair_t pop_next;

      assign w[i] = (FILL_W'(i) < fill) && pair_worse(dir, slot[i], pin);

      if (i == KEEP - 1) begin : g_end
        assign full_next = w[i] ? pin : slot[i];
        assign pop_next = slot[i];
      end else begin : g_mid
        assign full_next = w[i+1] ? slot[i+1] : (w[i] ? pin : slot[i]);
        assign pop_next = slot[i+1];
      end

      if (i == 0) begin : g_first
        assign open_next = w[i] ? slot[i] : pin;
      end else begin : g_rest
        assign open_next = w[i] ? slot[i] : (w[i-1] ? pin : slot[i-1]);
      end

      always_comb begin
        if (cmd.ins) begin
          slot_next[i] = full ? full_next : open_next;
        end else if (cmd.pop) begin
          slot_next[i] = pop_next;
        end else begin
          slot_next[i] = slot[i];
        end
      end

      always_ff @(posedge clk) begin
        slot[i] <= slot_next[i];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.ins && !full) begin
      fill <= fill + FILL_W'(1);
    end else if (cmd.pop && fill != '0) begin
      fill <= fill - FILL_W'(1);
    end
  end
endmodule

@@ rtl/tbk_merge.sv @@
// Drain merge stage: picks the first nonempty lane, pops its head into the output register.
`timescale 1ns / 1ps
module tbk_merge
  import tbk_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               drain,
  input  logic [FILL_W-1:0]  fills [NLISTS],
  input  pair_t              heads [NLISTS],
  output logic [NLISTS-1:0]  pop,
  output logic               done,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         stat_kind,
  output logic               direction,
  output logic signed [63:0] kept_value,
  output logic [63:0]        kept_name,
  output logic               last
);
  logic [LIST_W-1:0] sel;
  logic any;
  logic later;
  logic load;

  always_comb begin
    sel = '0;
    any = 1'b0;
    for (int l = NLISTS - 1; l >= 0; l--) begin
      if (fills[l] != '0) begin
        sel = LIST_W'(l);
        any = 1'b1;
      end
    end
  end

  always_comb begin
    later = 1'b0;
    for (int l = 0; l < NLISTS; l++) begin
      if (LIST_W'(l) > sel && fills[l] != '0) begin
        later = 1'b1;
      end
    end
  end

  assign load = drain && any && (!out_valid || !out_stall);
  assign done = drain && !any;

  always_comb begin
    pop = '0;
    pop[sel] = load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stat_kind  <= 2'(sel >> 1);
      direction  <= sel[0];
      kept_value <= heads[sel].value;
      kept_name  <= heads[sel].name;
      last       <= (fills[sel] == FILL_W'(1)) && !later;
    end
  end
endmodule

@@ rtl/streaming_top_bottom_k_tracker.sv @@
// Top level of the streaming top/bottom K tracker: control, six list lanes and the merge stage.
//
//   channel  | direction | handshake            | fields
//   input    | in        | in_valid / in_stall  | func, bytes_count, word_count, line_count, name_key
//   output   | out       | out_valid / out_stall| stat_kind, direction, kept_value, kept_name, last
//
// An insert word is first registered, then all six lanes update at once in the insert state.
// A drain pops one kept entry per cycle while the output is not stalled.
// The output register lets a word be accepted while a finished result still waits.
// Reset empties every list; slot contents are left as they are.
`timescale 1ns / 1ps
module streaming_top_bottom_k_tracker
  import tbk_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic signed [63:0] bytes_count,
  input  logic signed [63:0] word_count,
  input  logic signed [63:0] line_count,
  input  logic [63:0]        name_key,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         stat_kind,
  output logic               direction,
  output logic signed [63:0] kept_value,
  output logic [63:0]        kept_name,
  output logic               last
);
  state_t state;
  state_t state_next;
  logic signed [63:0] cnt [NSTATS];
  logic [63:0] name;
  logic accept;
  logic done;
  logic [NLISTS-1:0] pop;
  logic [FILL_W-1:0] fills [NLISTS];
  pair_t heads [NLISTS];

  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt[0] <= bytes_count;
      cnt[1] <= word_count;
      cnt[2] <= line_count;
      name   <= name_key;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = func ? ST_DRAIN : ST_INSERT;
        end
      end
      ST_INSERT: state_next = ST_IDLE;
      ST_DRAIN: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  genvar l;
  generate
    for (l = 0; l < NLISTS; l++) begin : g_lane
      lane_cmd_t cmd;
      pair_t pin;
      assign cmd.ins = (state == ST_INSERT);
      assign cmd.pop = pop[l];
      assign pin.value = cnt[l / 2];
      assign pin.name = name;

      tbk_lane u_lane (
        .clk  (clk),
        .rst  (rst),
        .dir  ((l % 2) == 1 ? DIR_BOT : DIR_TOP),
        .cmd  (cmd),
        .pin  (pin),
        .head (heads[l]),
        .fill (fills[l])
      );
    end
  endgenerate

  tbk_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .drain      (state == ST_DRAIN),
    .fills      (fills),
    .heads      (heads),
    .pop        (pop),
    .done       (done),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat_kind  (stat_kind),
    .direction  (direction),
    .kept_value (kept_value),
    .kept_name  (kept_name),
    .last       (last)
  );
endmodule

@@ rtl/tbk_checker.sv @@
// Port-level checker for the tracker, bound to the top level.
`timescale 1ns / 1ps
module tbk_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  stat_kind,
  input logic        last
);
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("Input not stalled after a word was accepted.");

  a_drain_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> out_valid)
    else $error("Drain stopped before its last word.");

  a_busy_in_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> in_stall)
    else $error("Input accepted in the middle of a drain.");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (stat_kind != 2'd3))
    else $error("Output word has an invalid statistic kind.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("Output word dropped while stalled.");
endmodule

bind streaming_top_bottom_k_tracker tbk_port_checker u_tbk_port_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .stat_kind (stat_kind),
  .last      (last)
);

@@ verif/tbk_checker.sv @@
// Checker for the top/bottom K tracker: watches both channels, predicts drained entries, compares.
`timescale 1ns / 1ps
module tbk_checker
  import tbk_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               func,
  input  logic signed [63:0] bytes_count,
  input  logic signed [63:0] word_count,
  input  logic signed [63:0] line_count,
  input  logic [63:0]        name_key,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         stat_kind,
  input  logic               direction,
  input  logic signed [63:0] kept_value,
  input  logic [63:0]        kept_name,
  input  logic               last,
  output int                 errors,
  output int                 pending,
  output int                 results_seen
);
  typedef struct {
    logic [1:0]         kind;
    logic               dir;
    logic signed [63:0] value;
    logic [63:0]        name;
    logic               last;
  } kept_entry_t;

  logic signed [63:0] kept_vals [NLISTS][KEEP];
  logic [63:0]        kept_names[NLISTS][KEEP];
  int                 fill[NLISTS];
  kept_entry_t        drain_q[$];

  function automatic bit ranks_below(logic dir, logic signed [63:0] av, logic [63:0] an,
                                     logic signed [63:0] bv, logic [63:0] bn);
    logic signed [63:0] lv, hv;
    logic [63:0] ln, hn;
    if (dir == DIR_TOP) begin
      lv = av; ln = an; hv = bv; hn = bn;
    end else begin
      lv = bv; ln = bn; hv = av; hn = an;
    end
    if (lv != hv) return lv < hv;
    return ln < hn;
  endfunction

  task automatic keep_pair(int lst, logic signed [63:0] v, logic [63:0] n);
    logic dir;
    int   cnt, pos;
    dir = lst[0];
    cnt = fill[lst];
    if (cnt == KEEP) begin
      if (!ranks_below(dir, kept_vals[lst][0], kept_names[lst][0], v, n)) return;
      for (int i = 0; i < KEEP - 1; i++) begin
        kept_vals[lst][i] = kept_vals[lst][i + 1];
        kept_names[lst][i] = kept_names[lst][i + 1];
      end
      cnt = KEEP - 1;
    end
    pos = 0;
    for (int i = 0; i < cnt; i++)
      if (ranks_below(dir, kept_vals[lst][i], kept_names[lst][i], v, n)) pos = i + 1;
    for (int i = cnt; i > pos; i--) begin
      kept_vals[lst][i] = kept_vals[lst][i - 1];
      kept_names[lst][i] = kept_names[lst][i - 1];
    end
    kept_vals[lst][pos] = v;
    kept_names[lst][pos] = n;
    fill[lst] = cnt + 1;
  endtask

  task automatic drain_lists();
    kept_entry_t e;
    int start;
    start = drain_q.size();
    for (int l = 0; l < NLISTS; l++) begin
      for (int i = 0; i < fill[l]; i++) begin
        e.kind = 2'(l / 2);
        e.dir = l[0];
        e.value = kept_vals[l][i];
        e.name = kept_names[l][i];
        e.last = 1'b0;
        drain_q.insert(drain_q.size(), e);
      end
      fill[l] = 0;
    end
    if (drain_q.size() > start) drain_q[drain_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    kept_entry_t e;
    if (rst) begin
      for (int l = 0; l < NLISTS; l++) fill[l] = 0;
      drain_q.delete();
      errors = 0;
      results_seen = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (drain_q.size() == 0) begin
          $error("Result word with nothing expected: value %0d name %h", kept_value, kept_name);
          errors++;
        end else begin
          e = drain_q.pop_front();
          if (stat_kind !== e.kind) begin
            $error("stat_kind expected %0d actual %0d", e.kind, stat_kind); errors++;
          end
          if (direction !== e.dir) begin
            $error("direction expected %0d actual %0d", e.dir, direction); errors++;
          end
          if (kept_value !== e.value) begin
            $error("kept_value expected %0d actual %0d", e.value, kept_value); errors++;
          end
          if (kept_name !== e.name) begin
            $error("kept_name expected %h actual %h", e.name, kept_name); errors++;
          end
          if (last !== e.last) begin
            $error("last expected %0d actual %0d", e.last, last); errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (func == 1'b0) begin
          for (int s = 0; s < NSTATS; s++) begin
            logic signed [63:0] v;
            v = (s == 0) ? bytes_count : (s == 1) ? word_count : line_count;
            keep_pair(2 * s, v, name_key);
            keep_pair(2 * s + 1, v, name_key);
          end
        end else begin
          drain_lists();
        end
      end
    end
    pending = drain_q.size();
  end
endmodule

@@ verif/tb.sv @@
// Testbench top for the top/bottom K tracker: stimulus, idling, timeout and verdict.
`timescale 1ns / 1ps
module tb;
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DRAIN  = 1'b1;
  localparam longint MAX_CYCLES = 400000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               func = FUNC_INSERT;
  logic signed [63:0] bytes_count = '0;
  logic signed [63:0] word_count = '0;
  logic signed [63:0] line_count = '0;
  logic [63:0]        name_key = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         stat_kind;
  logic               direction;
  logic signed [63:0] kept_value;
  logic [63:0]        kept_name;
  logic               last;
  int                 errors, pending, results_seen;
  int                 drains_sent;
  bit                 calm = 1'b0;
  longint             cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  streaming_top_bottom_k_tracker i_dut (.*);

  tbk_checker i_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver stalls in random bursts until the quiet tail of the run.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  function automatic logic [63:0] pick_value(int mode);
    case (mode)
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return 64'($signed($urandom_range(0, 15)) - 8);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_word(logic f, logic [63:0] b, logic [63:0] w, logic [63:0] l,
                           logic [63:0] n);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    func <= f;
    bytes_count <= b;
    word_count <= w;
    line_count <= l;
    name_key <= n;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (f == FUNC_DRAIN) drains_sent++;
  endtask

  task automatic send_random_record();
    logic [63:0] n;
    n = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 3)) : {$urandom, $urandom};
    send_word(FUNC_INSERT, pick_value($urandom_range(0, 9)), pick_value($urandom_range(0, 9)),
              pick_value($urandom_range(0, 9)), n);
  endtask

  initial begin
    drains_sent = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // Drain of empty lists, then extremes, ties on value and on name, and overflow of a list.
    send_word(FUNC_DRAIN, '1, '1, '1, '1);
    send_word(FUNC_INSERT, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 0, '1);
    send_word(FUNC_INSERT, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, '1, 0);
    send_word(FUNC_INSERT, 5, 5, 5, 64'h10);
    send_word(FUNC_INSERT, 5, 5, 5, 64'h10);
    send_word(FUNC_INSERT, 5, 5, 5, 64'h0f);
    send_word(FUNC_DRAIN, 64'h1234, 0, 0, 0);
    for (int i = 0; i < 14; i++)
      send_word(FUNC_INSERT, 64'(i), -64'(i), 64'(i % 3), 64'($urandom_range(0, 2)));
    send_word(FUNC_DRAIN, 0, 0, 0, 0);
    // Random phases: bursts of records, some long enough to fill lists, each closed by a drain.
    while (drains_sent < 11) begin
      repeat ($urandom_range(1, 14)) send_random_record();
      send_word(FUNC_DRAIN, {$urandom, $urandom}, 0, 0, 0);
    end
    calm = 1'b1;
    repeat (8) send_random_record();
    send_word(FUNC_DRAIN, 0, 0, 0, 0);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d drains and %0d kept entries, with field extremes, ties and full lists.",
             drains_sent, results_seen);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/tbk_pkg.sv
rtl/tbk_lane.sv
rtl/tbk_merge.sv
rtl/streaming_top_bottom_k_tracker.sv
rtl/tbk_checker.sv
verif/tbk_checker.sv
verif/tb.sv
